FILE: src/ctts_pkg.sv
// ----------------------------------------------------------------------------
// ctts_pkg
// Command, slot mode and result kind codes shared by the task table scheduler.
// ----------------------------------------------------------------------------
package ctts_pkg;

   typedef enum logic [2:0] {
      CMD_ADD      = 3'd0,
      CMD_EXIT     = 3'd1,
      CMD_SLEEP    = 3'd2,
      CMD_SUSPEND  = 3'd3,
      CMD_RESUME   = 3'd4,
      CMD_TICK     = 3'd5,
      CMD_SCHEDULE = 3'd6
   } command_type;

   typedef enum logic [1:0] {
      MODE_EMPTY = 2'd0,
      MODE_READY = 2'd1,
      MODE_SUSP  = 2'd2,
      MODE_SLEEP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_RUN     = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   localparam logic [15:0] SLEEP_CAP_RESET = 16'hFFFF;

endpackage

FILE: src/ctts_ram.sv
// ----------------------------------------------------------------------------
// ctts_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ctts_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cooperative_task_table_scheduler.sv
// ----------------------------------------------------------------------------
// cooperative_task_table_scheduler
// Task slot table with add, exit, sleep, suspend, resume, tick and schedule.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_ready is high only while the sequencer
// is idle, and it is high again while the last response still waits in the
// output register. Sleep, suspend, resume, a full add, a rejected command and
// an unknown code go from accept to acknowledge. A successful add or exit
// first rescans the occupancy bits, one slot per cycle, to find the lowest
// free and highest used slot. In tick and schedule, each slot up to the
// highest used one goes through the single slot RAM (address, then registered
// read data, with the tick write-back in the same cycle as the data); a
// schedule also waits on rsp_ready for each run response. The sleep_cap
// register is written through the csr port, which is always ready.
// ----------------------------------------------------------------------------
module cooperative_task_table_scheduler #(
   parameter int TASK_SLOTS = 8,
   parameter int TICK_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_sleep_cap,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_task_slot,
   output logic        rsp_ok,
   output logic [3:0]  rsp_free_count,
   output logic [15:0] rsp_min_sleep,
   output logic        rsp_is_last
);

   import ctts_pkg::*;

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int FW = $clog2(TASK_SLOTS + 1);
   localparam int TB = TICK_BITS;
   localparam int WW = TICK_BITS + 2;
   localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;
   localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESCAN,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_ACK
   } state_type;

   state_type           state_ff, state_in;
   logic [TASK_SLOTS-1:0] used_ff, used_in;
   logic [FW-1:0]       free_total_ff, free_total_in;
   logic [IW-1:0]       first_free_ff, first_free_in;
   logic [IW-1:0]       highest_used_ff, highest_used_in;
   logic [15:0]         sleep_cap_ff, sleep_cap_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic                is_sched_ff, is_sched_in;
   logic                any_ready_ff, any_ready_in;
   logic [15:0]         mins_ff, mins_in;
   kind_type            fin_kind_ff, fin_kind_in;
   logic [2:0]          fin_slot_ff, fin_slot_in;
   logic                fin_ok_ff, fin_ok_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [2:0]          rsp_slot_ff, rsp_slot_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [3:0]          rsp_free_ff, rsp_free_in;
   logic [15:0]         rsp_mins_ff, rsp_mins_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                ram_wr_en;
   logic [IW-1:0]       ram_wr_addr;
   logic [WW-1:0]       ram_wr_data;
   logic                ram_rd_en;
   logic [WW-1:0]       ram_rd_data;

   logic                rsp_free;
   logic [IW-1:0]       slot_idx;
   logic                live;
   logic [31:0]         ticks_wide;
   logic [TB-1:0]       ticks_st;
   mode_type            ev_mode;
   logic [TB-1:0]       ev_sleep;

   // each slot keeps {mode, sleep counter}; occupancy bits gate stale entries
   ctts_ram #(
      .WIDTH(WW),
      .DEPTH(TASK_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign slot_idx   = IW'(req_slot);
   assign live       = ({29'd0, req_slot} < TASK_SLOTS) && used_ff[slot_idx];
   assign ticks_wide = {16'd0, req_ticks};
   assign ticks_st   = ticks_wide[TB-1:0];
   assign ev_mode    = used_ff[idx_ff] ? mode_type'(ram_rd_data[WW-1:TB]) : MODE_EMPTY;
   assign ev_sleep   = ram_rd_data[TB-1:0];

   always_comb begin
      state_in        = state_ff;
      used_in         = used_ff;
      free_total_in   = free_total_ff;
      first_free_in   = first_free_ff;
      highest_used_in = highest_used_ff;
      sleep_cap_in    = sleep_cap_ff;
      idx_in          = idx_ff;
      found_in        = found_ff;
      is_sched_in     = is_sched_ff;
      any_ready_in    = any_ready_ff;
      mins_in         = mins_ff;
      fin_kind_in     = fin_kind_ff;
      fin_slot_in     = fin_slot_ff;
      fin_ok_in       = fin_ok_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_mins_in     = rsp_mins_ff;
      rsp_last_in     = rsp_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = slot_idx;
      ram_wr_data     = {MODE_READY, {TB{1'b0}}};
      ram_rd_en       = 1'b0;

      if (csr_valid) begin
         sleep_cap_in = csr_sleep_cap;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_kind_in  = KIND_ACK;
               fin_slot_in  = 3'd0;
               fin_ok_in    = live;
               any_ready_in = 1'b0;
               mins_in      = sleep_cap_ff;
               idx_in       = '0;
               found_in     = 1'b0;
               state_in     = ST_ACK;
               case (command_type'(req_command))
                  CMD_ADD: begin
                     if (free_total_ff == '0) begin
                        fin_ok_in = 1'b0;
                     end else begin
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = first_free_ff;
                        ram_wr_data            = {MODE_READY, {TB{1'b0}}};
                        used_in[first_free_ff] = 1'b1;
                        free_total_in          = free_total_ff - 1'b1;
                        fin_ok_in              = 1'b1;
                        fin_slot_in            = 3'(first_free_ff);
                        first_free_in          = '0;
                        highest_used_in        = '0;
                        state_in               = ST_RESCAN;
                     end
                  end
                  CMD_EXIT: begin
                     if (live) begin
                        used_in[slot_idx] = 1'b0;
                        free_total_in     = free_total_ff + 1'b1;
                        first_free_in     = '0;
                        highest_used_in   = '0;
                        state_in          = ST_RESCAN;
                     end
                  end
                  CMD_SLEEP: begin
                     ram_wr_en   = live;
                     ram_wr_data = {MODE_SLEEP, ticks_st};
                  end
                  CMD_SUSPEND: begin
                     ram_wr_en   = live;
                     ram_wr_data = {MODE_SUSP, {TB{1'b0}}};
                  end
                  CMD_RESUME: begin
                     ram_wr_en   = live;
                     ram_wr_data = {MODE_READY, {TB{1'b0}}};
                  end
                  CMD_TICK: begin
                     fin_ok_in   = 1'b1;
                     is_sched_in = 1'b0;
                     state_in    = ST_WALK_RD;
                  end
                  CMD_SCHEDULE: begin
                     fin_ok_in   = 1'b1;
                     is_sched_in = 1'b1;
                     state_in    = ST_WALK_RD;
                  end
                  default: begin
                     fin_ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_RESCAN: begin
            if (!used_ff[idx_ff] && !found_ff) begin
               first_free_in = idx_ff;
               found_in      = 1'b1;
            end
            if (used_ff[idx_ff]) begin
               highest_used_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_ACK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_WALK_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WALK_EV;
         end
         ST_WALK_EV: begin
            if (is_sched_ff && ev_mode == MODE_READY && !rsp_free) begin
               // run response blocked, hold this slot
               state_in = ST_WALK_EV;
            end else begin
               if (is_sched_ff) begin
                  if (ev_mode == MODE_READY) begin
                     any_ready_in = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_RUN;
                     rsp_slot_in  = 3'(idx_ff);
                     rsp_ok_in    = 1'b1;
                     rsp_free_in  = 4'(free_total_ff);
                     rsp_mins_in  = 16'd0;
                     rsp_last_in  = 1'b0;
                  end else if (ev_mode == MODE_SLEEP && CW'(ev_sleep) < CW'(mins_ff)) begin
                     mins_in = 16'(ev_sleep);
                  end
               end else if (ev_mode == MODE_SLEEP) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff;
                  if (ev_sleep != '0) begin
                     ram_wr_data = {MODE_SLEEP, ev_sleep - TB'(1)};
                  end else begin
                     ram_wr_data = {MODE_READY, ev_sleep};
                  end
               end
               if (idx_ff == highest_used_ff) begin
                  fin_kind_in = is_sched_ff ? KIND_SUMMARY : KIND_ACK;
                  state_in    = ST_ACK;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_ACK: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fin_kind_ff;
               rsp_slot_in  = fin_slot_ff;
               rsp_ok_in    = fin_ok_ff;
               rsp_free_in  = 4'(free_total_ff);
               rsp_mins_in  = (fin_kind_ff == KIND_SUMMARY && !any_ready_ff) ? mins_ff : 16'd0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         used_ff         <= '0;
         free_total_ff   <= FW'(TASK_SLOTS);
         first_free_ff   <= '0;
         highest_used_ff <= '0;
         sleep_cap_ff    <= SLEEP_CAP_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         used_ff         <= used_in;
         free_total_ff   <= free_total_in;
         first_free_ff   <= first_free_in;
         highest_used_ff <= highest_used_in;
         sleep_cap_ff    <= sleep_cap_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      is_sched_ff  <= is_sched_in;
      any_ready_ff <= any_ready_in;
      mins_ff      <= mins_in;
      fin_kind_ff  <= fin_kind_in;
      fin_slot_ff  <= fin_slot_in;
      fin_ok_ff    <= fin_ok_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_mins_ff  <= rsp_mins_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_task_slot   = rsp_slot_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_free_count  = rsp_free_ff;
   assign rsp_min_sleep   = rsp_mins_ff;
   assign rsp_is_last     = rsp_last_ff;

   // free count and occupancy bits always agree
   a_free_matches_used: assert property (@(posedge clock) disable iff (reset)
      ($countones(used_ff) + int'(free_total_ff)) == TASK_SLOTS)
      else $error("free count does not match occupancy");

   // outside a rescan the lowest free slot is really free
   a_first_free_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && free_total_ff != '0) |-> !used_ff[first_free_ff])
      else $error("first free slot is occupied");

   // outside a rescan the highest used slot is occupied when any slot is
   a_highest_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && free_total_ff != FW'(TASK_SLOTS)) |-> used_ff[highest_used_ff])
      else $error("highest used slot is empty");

   // a run response is never the last one of a schedule
   a_run_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_RUN) |-> (!rsp_last_ff && state_ff != ST_IDLE))
      else $error("run response closes the request");

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
